FILE: design/pth_pkg.sv
package pth_pkg;

  // Build-time defaults for the grid geometry
  localparam int unsigned HEX_SIZE_DEF  = 64;
  localparam int unsigned GRID_COLS_DEF = 32;
  localparam int unsigned GRID_ROWS_DEF = 32;

  // Signed quotient width: covers a 16-bit coordinate shifted by half a hex
  localparam int unsigned QUO_W = 17;
  // Cell-local coordinate width: holds 0 .. HEX_SIZE-1 for HEX_SIZE up to 256
  localparam int unsigned LOC_W = 8;

  typedef struct packed {
    logic signed [15:0] world_x;
    logic signed [15:0] world_y;
  } pth_in_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] column;
    logic [4:0] row;
    logic [9:0] cell_index;
  } pth_res_t;

  // Band cell found by the dividers, before the corner fix-up
  typedef struct packed {
    logic signed [QUO_W-1:0] col;
    logic signed [QUO_W-1:0] row;
    logic [LOC_W-1:0]        lx;
    logic [LOC_W-1:0]        ly;
    logic                    odd;
  } pth_cell_t;

endpackage

FILE: design/pixel_to_hex_cell.sv
// Pixel to hex cell lookup, pointy-top hexagons, odd rows shifted right.
//
// Input beat: start_i with in_i (world_x, world_y, signed pixels). A beat is
// taken at every clock edge where start_i is high and busy_o is low; busy_o
// is never raised, so a new coordinate pair may be issued every cycle.
// Output beat: done_o is high for exactly one cycle with res_o (hit, column,
// row, cell_index). A miss returns hit = 0 and all other fields zero.
//
// Stages: input register, reciprocal-multiply estimate for the row band and
// both column candidates, remainder correction with the odd-row column
// select, then corner-triangle fix-up and grid range check.
// Throughput: one beat per cycle; every stage is a plain pipeline register.
//
// Reset clears only the beat valid flags; data registers are not reset.
// The receiver has no back-pressure: each result is presented once and
// must be taken in that cycle.
module pixel_to_hex_cell #(
  parameter int unsigned HEX_SIZE  = pth_pkg::HEX_SIZE_DEF,
  parameter int unsigned GRID_COLS = pth_pkg::GRID_COLS_DEF,
  parameter int unsigned GRID_ROWS = pth_pkg::GRID_ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  pth_pkg::pth_in_t  in_i,
  output logic              done_o,
  output pth_pkg::pth_res_t res_o
);
  import pth_pkg::*;

  localparam int unsigned ROWSTEP = HEX_SIZE * 3 / 4;

  // Beat valid flags, one per pipeline register
  logic v_in_q, v_div_q, v_cell_q, done_q;

  pth_in_t   in_q;
  pth_cell_t cell_d, cell_q;
  pth_res_t  res_d, res_q;

  logic signed [QUO_W-1:0] py, px, pxs;
  logic signed [QUO_W-1:0] row_b, col_e, col_o;
  logic [LOC_W-1:0]        ly_b, lx_e, lx_o;

  assign busy_o = 1'b0;

  // Input register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      in_q <= in_i;
    end
  end

  // Sign-extend; odd-row candidate is shifted left by half a hex
  assign py  = {in_q.world_y[15], in_q.world_y};
  assign px  = {in_q.world_x[15], in_q.world_x};
  assign pxs = px - QUO_W'(HEX_SIZE / 2);

  pth_fdiv #(.DIVISOR(ROWSTEP)) u_div_row (
    .clk_i (clk_i),
    .a_i   (py),
    .quo_o (row_b),
    .rem_o (ly_b)
  );

  pth_fdiv #(.DIVISOR(HEX_SIZE)) u_div_col_even (
    .clk_i (clk_i),
    .a_i   (px),
    .quo_o (col_e),
    .rem_o (lx_e)
  );

  pth_fdiv #(.DIVISOR(HEX_SIZE)) u_div_col_odd (
    .clk_i (clk_i),
    .a_i   (pxs),
    .quo_o (col_o),
    .rem_o (lx_o)
  );

  // Row parity picks the column candidate
  always_comb begin
    cell_d.row = row_b;
    cell_d.ly  = ly_b;
    cell_d.odd = row_b[0];
    cell_d.col = row_b[0] ? col_o : col_e;
    cell_d.lx  = row_b[0] ? lx_o  : lx_e;
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  pth_corner #(
    .HEX_SIZE  (HEX_SIZE),
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_corner (
    .cell_i (cell_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_in_q   <= 1'b0;
      v_div_q  <= 1'b0;
      v_cell_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      v_in_q   <= start_i;
      v_div_q  <= v_in_q;
      v_cell_q <= v_div_q;
      done_q   <= v_cell_q;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // Every accepted beat comes out as a done_o strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##4 done_o)
    else $error("result strobe missing four cycles after accept");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 4))
    else $error("result strobe without matching accepted beat");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.hit |->
      res_o.column == 5'd0 && res_o.row == 5'd0 && res_o.cell_index == 10'd0)
    else $error("miss result carries nonzero fields");

  a_hit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.hit |->
      res_o.cell_index == 10'(10'(res_o.column) + 10'(res_o.row) * 10'(GRID_COLS)))
    else $error("cell index does not match column and row");

endmodule

FILE: design/pth_fdiv.sv
module pth_fdiv #(
  parameter int unsigned DIVISOR = 48
) (
  input  logic                               clk_i,
  input  logic signed [pth_pkg::QUO_W-1:0]   a_i,
  output logic signed [pth_pkg::QUO_W-1:0]   quo_o,
  output logic [pth_pkg::LOC_W-1:0]          rem_o
);
  import pth_pkg::*;

  // Bias the dividend by a multiple of the divisor so the divide is unsigned
  localparam int unsigned KOFS  = (65536 + DIVISOR - 1) / DIVISOR;
  localparam int unsigned OFS   = KOFS * DIVISOR;
  // Truncated reciprocal: estimate is low by at most one
  localparam int unsigned RECIP = (1 << QUO_W) / DIVISOR;

  logic [QUO_W:0]     biased;
  logic [QUO_W-1:0]   u_d, u_q;
  logic [2*QUO_W-1:0] prod;
  logic [QUO_W-1:0]   qe_d, qe_q;
  logic [QUO_W-1:0]   back;
  logic [QUO_W-1:0]   rem0;
  logic               fix;
  logic [QUO_W-1:0]   q_u;
  logic [QUO_W-1:0]   rem1;

  assign biased = {a_i[QUO_W-1], a_i} + (QUO_W+1)'(OFS);
  assign u_d    = biased[QUO_W-1:0];
  assign prod   = (2*QUO_W)'(u_d) * (2*QUO_W)'(RECIP);
  assign qe_d   = prod[2*QUO_W-1:QUO_W];

  always_ff @(posedge clk_i) begin
    u_q  <= u_d;
    qe_q <= qe_d;
  end

  // One correction step: remainder lies in [0, 2*DIVISOR)
  assign back  = qe_q * QUO_W'(DIVISOR);
  assign rem0  = u_q - back;
  assign fix   = rem0 >= QUO_W'(DIVISOR);
  assign q_u   = qe_q + QUO_W'(fix);
  assign rem1  = fix ? rem0 - QUO_W'(DIVISOR) : rem0;
  assign quo_o = $signed(q_u - QUO_W'(KOFS));
  assign rem_o = rem1[LOC_W-1:0];

endmodule

FILE: design/pth_corner.sv
module pth_corner #(
  parameter int unsigned HEX_SIZE  = 64,
  parameter int unsigned GRID_COLS = 32,
  parameter int unsigned GRID_ROWS = 32
) (
  input  pth_pkg::pth_cell_t cell_i,
  output pth_pkg::pth_res_t  res_o
);
  import pth_pkg::*;

  localparam int unsigned LIM_W = LOC_W + 2;

  logic [LOC_W-1:0]        ye;
  logic [LIM_W-1:0]        ye2;
  logic [LIM_W-1:0]        lx_w;
  logic                    in_band;
  logic                    left;
  logic                    right;
  logic signed [QUO_W-1:0] col_a;
  logic signed [QUO_W-1:0] row_a;
  logic                    hit;

  assign ye      = {cell_i.ly[LOC_W-1:1], 1'b0};
  assign ye2     = {1'b0, ye, 1'b0};
  assign lx_w    = LIM_W'(cell_i.lx);
  assign in_band = ye < LOC_W'(HEX_SIZE / 4);
  assign left    = in_band && ((lx_w + ye2) < LIM_W'(HEX_SIZE / 2 - 1));
  assign right   = in_band && (lx_w > (LIM_W'(HEX_SIZE / 2) + ye2));

  // Top corners belong to the row above; column shift depends on band parity
  always_comb begin
    col_a = cell_i.col;
    row_a = cell_i.row;
    if (left) begin
      row_a = cell_i.row - QUO_W'(1);
      if (!cell_i.odd) begin
        col_a = cell_i.col - QUO_W'(1);
      end
    end else if (right) begin
      row_a = cell_i.row - QUO_W'(1);
      if (cell_i.odd) begin
        col_a = cell_i.col + QUO_W'(1);
      end
    end
  end

  assign hit = !col_a[QUO_W-1] && (col_a < $signed(QUO_W'(GRID_COLS)))
            && !row_a[QUO_W-1] && (row_a < $signed(QUO_W'(GRID_ROWS)));

  always_comb begin
    res_o = '0;
    if (hit) begin
      res_o.hit        = 1'b1;
      res_o.column     = col_a[4:0];
      res_o.row        = row_a[4:0];
      res_o.cell_index = 10'(col_a[9:0] + row_a[9:0] * 10'(GRID_COLS));
    end
  end

endmodule
